// File: src/snsl_pkg.sv
// scoped name stack lookup: shared opcodes, status codes, controller states
// and the command/status structs between controller and datapath
// no dependencies
`timescale 1ns / 1ps

package snsl_pkg;

    localparam logic [1:0] OP_PUSH_BIND  = 2'd0;
    localparam logic [1:0] OP_PUSH_SCOPE = 2'd1;
    localparam logic [1:0] OP_DROP_SCOPE = 2'd2;
    localparam logic [1:0] OP_LOOKUP     = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam int          OPCODE_W  = 2;
    localparam int          NAME_W    = 16;
    localparam int          HANDLE_W  = 32;
    localparam int          STATUS_W  = 2;
    localparam int          INDEX_W   = 6;
    localparam logic [5:0]  INDEX_MAX = 6'd63;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic step;
        logic load_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic empty;
        logic walk_end;
        logic out_free;
    } dp_stat_t;

endpackage

// File: src/snsl_ram.sv
// scoped name stack lookup: generic single write port ram, registered read
// no dependencies
`timescale 1ns / 1ps

module snsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/snsl_ctrl.sv
// scoped name stack lookup: controller state machine
// depends on snsl_pkg
`timescale 1ns / 1ps

module snsl_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  snsl_pkg::dp_stat_t stat,
    output snsl_pkg::ctl_cmd_t cmd
);

    import snsl_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    // drop and lookup on a non-empty stack need the walk
                    if ((s_opcode == OP_DROP_SCOPE || s_opcode == OP_LOOKUP) && !stat.empty) begin
                        state_next = S_WALK;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_WALK: begin
                cmd.step = 1'b1;
                if (stat.walk_end) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: src/snsl_datapath.sv
// scoped name stack lookup: entry ram, stack count, walk pointer, result
// and output registers
// depends on snsl_pkg and snsl_ram
`timescale 1ns / 1ps

module snsl_datapath #(
    parameter int STACK_DEPTH = 64,
    parameter int NAME_BITS   = 16,
    parameter int HANDLE_BITS = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [snsl_pkg::OPCODE_W-1:0]    s_opcode,
    input  logic [snsl_pkg::NAME_W-1:0]      s_name_id,
    input  logic [snsl_pkg::HANDLE_W-1:0]    s_value_handle,
    input  snsl_pkg::ctl_cmd_t               cmd,
    output snsl_pkg::dp_stat_t               stat,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [snsl_pkg::STATUS_W-1:0]    m_status,
    output logic [snsl_pkg::INDEX_W-1:0]     m_match_index,
    output logic [snsl_pkg::HANDLE_W-1:0]    m_found_handle
);

    import snsl_pkg::*;

    localparam int NW = (NAME_BITS < NAME_W) ? NAME_BITS : NAME_W;
    localparam int HW = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int DW = 1 + NW + HW;

    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [CW-1:0]       seen_reg, seen_next;
    logic [1:0]          op_reg, op_next;
    logic [NW-1:0]       name_reg, name_next;
    logic [1:0]          res_status_reg, res_status_next;
    logic [INDEX_W-1:0]  res_index_reg, res_index_next;
    logic [HANDLE_W-1:0] res_handle_reg, res_handle_next;
    logic                out_valid_reg;
    logic [1:0]          out_status_reg;
    logic [INDEX_W-1:0]  out_index_reg;
    logic [HANDLE_W-1:0] out_handle_reg;

    logic          full;
    logic          is_push;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;
    logic [CW-1:0] count_m1;
    logic          rd_mark;
    logic [NW-1:0] rd_name;
    logic [HW-1:0] rd_handle;
    logic          hit;
    logic          pos_zero;
    logic [INDEX_W-1:0] seen_sat;

    assign full      = (count_reg == CW'(STACK_DEPTH));
    assign is_push   = (s_opcode == OP_PUSH_BIND) || (s_opcode == OP_PUSH_SCOPE);
    assign ram_we    = cmd.accept && is_push && !full;
    assign ram_waddr = count_reg[AW-1:0];
    assign ram_wdata = (s_opcode == OP_PUSH_SCOPE) ? {1'b1, {(NW + HW){1'b0}}}
                                                   : {1'b0, s_name_id[NW-1:0],
                                                      s_value_handle[HW-1:0]};
    assign count_m1  = count_reg - CW'(1);
    // on accept read the top entry, while walking read one below the current
    assign ram_raddr = cmd.step ? (pos_reg - AW'(1)) : count_m1[AW-1:0];

    snsl_ram #(
        .WIDTH (DW),
        .DEPTH (STACK_DEPTH)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_mark   = ram_rdata[DW-1];
    assign rd_name   = ram_rdata[DW-2 -: NW];
    assign rd_handle = ram_rdata[HW-1:0];
    assign hit       = !rd_mark && (rd_name == name_reg);
    assign pos_zero  = (pos_reg == '0);
    assign seen_sat  = (32'(seen_reg) > 32'(INDEX_MAX)) ? INDEX_MAX : INDEX_W'(seen_reg);

    assign stat.empty    = (count_reg == '0);
    assign stat.walk_end = (op_reg == OP_LOOKUP) ? (hit || pos_zero) : (rd_mark || pos_zero);
    assign stat.out_free = !out_valid_reg || m_ready;

    always_comb begin
        count_next      = count_reg;
        pos_next        = pos_reg;
        seen_next       = seen_reg;
        op_next         = op_reg;
        name_next       = name_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_handle_next = res_handle_reg;
        if (cmd.accept) begin
            op_next         = s_opcode;
            name_next       = s_name_id[NW-1:0];
            pos_next        = count_m1[AW-1:0];
            seen_next       = '0;
            res_index_next  = '0;
            res_handle_next = '0;
            unique case (s_opcode)
                OP_PUSH_BIND, OP_PUSH_SCOPE: begin
                    res_status_next = full ? ST_FULL : ST_OK;
                    if (!full) begin
                        count_next = count_reg + CW'(1);
                    end
                end
                OP_DROP_SCOPE: res_status_next = ST_EMPTY;
                OP_LOOKUP:     res_status_next = ST_NOT_FOUND;
                default:       res_status_next = ST_OK;
            endcase
        end else if (cmd.step) begin
            pos_next  = pos_reg - AW'(1);
            seen_next = seen_reg + CW'(!rd_mark);
            if (op_reg == OP_LOOKUP) begin
                if (hit) begin
                    res_status_next = ST_OK;
                    res_index_next  = seen_sat;
                    res_handle_next = HANDLE_W'(rd_handle);
                end else begin
                    res_status_next = ST_NOT_FOUND;
                end
            end else begin
                res_status_next = ST_OK;
                if (rd_mark || pos_zero) begin
                    // pop down to and including the marker
                    count_next = rd_mark ? CW'(pos_reg) : '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg        <= pos_next;
        seen_reg       <= seen_next;
        op_reg         <= op_next;
        name_reg       <= name_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_handle_reg <= res_handle_next;
        if (cmd.load_out) begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= res_index_reg;
            out_handle_reg <= res_handle_reg;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_status       = out_status_reg;
    assign m_match_index  = out_index_reg;
    assign m_found_handle = out_handle_reg;

endmodule

// File: src/scoped_name_stack_lookup_top.sv
// scoped name stack lookup: top level, controller plus datapath
// depends on snsl_pkg, snsl_ctrl, snsl_datapath
`timescale 1ns / 1ps

// Scoped symbol stack with de Bruijn lookup. Each request gives exactly one
// result. Push binding and push scope write the entry RAM on acceptance unless
// the stack is full, and go straight to their result. Drop scope and lookup walk
// the stack from the top, one entry per cycle through the single read port of
// the entry RAM, visiting at most the current fill, so up to STACK_DEPTH
// entries. Lookup or drop on an empty stack skips the walk. The block works on
// one request at a time; the next can be accepted in the cycle after the previous
// result has moved into the output register, which holds it until taken. The
// entry RAM needs no clearing after reset.

module scoped_name_stack_lookup_top #(
    parameter int STACK_DEPTH = 64,
    parameter int NAME_BITS   = 16,
    parameter int HANDLE_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [snsl_pkg::OPCODE_W-1:0] s_opcode,
    input  logic [snsl_pkg::NAME_W-1:0]   s_name_id,
    input  logic [snsl_pkg::HANDLE_W-1:0] s_value_handle,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [snsl_pkg::STATUS_W-1:0] m_status,
    output logic [snsl_pkg::INDEX_W-1:0]  m_match_index,
    output logic [snsl_pkg::HANDLE_W-1:0] m_found_handle
);

    import snsl_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    snsl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .stat     (stat),
        .cmd      (cmd)
    );

    snsl_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .NAME_BITS   (NAME_BITS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_opcode       (s_opcode),
        .s_name_id      (s_name_id),
        .s_value_handle (s_value_handle),
        .cmd            (cmd),
        .stat           (stat),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_match_index  (m_match_index),
        .m_found_handle (m_found_handle)
    );

    // a result may only enter the output register when it is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> stat.out_free)
        else $error("result loaded over a pending output");

    // only one controller command at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.accept, cmd.step, cmd.load_out}))
        else $error("overlapping controller commands");

    // a request is taken only through the handshake
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |-> (s_valid && s_ready))
        else $error("request taken without handshake");

    // a push binding that is not full leaves a non-empty stack
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && s_opcode == OP_PUSH_BIND) |=> !stat.empty)
        else $error("stack empty after push");

    // loading a result always raises the output valid
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_valid)
        else $error("output valid not raised after load");

endmodule
